@@ design/tdsm_pkg.sv @@
`default_nettype none
package tdsm_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_CMD  = 2'd1,
    OP_DATA = 2'd2,
    OP_READ = 2'd3
  } op_t;

  localparam int SEND_BITS_DEFAULT = 8;

  localparam logic [3:0] PHASE_CLK_FALL  = 4'd7;
  localparam logic [3:0] PHASE_SAMPLE    = 4'd11;
  localparam logic [3:0] PHASE_LAST      = 4'd15;
  localparam logic [3:0] FRAME_SELECT    = 4'd0;
  localparam logic [3:0] FRAME_CLEAR     = 4'd1;
  localparam logic [3:0] FRAME_FIRST_BIT = 4'd2;
  localparam logic [3:0] FRAME_LAST_BIT  = 4'd9;
  localparam logic [3:0] FRAME_LAST      = 4'd11;

  typedef struct packed {
    logic start;
    logic tick;
    logic din;
  } read_ctrl_t;

  typedef struct packed {
    logic       active;
    logic       adc_clock;
    logic       adc_select_n;
    logic [7:0] sample;
  } read_status_t;

endpackage
`default_nettype wire

@@ design/tdsm_in_if.sv @@
`default_nettype none
interface tdsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  logic       adc_data_in;

  modport source (output valid, operation, byte_value, adc_data_in, input ready);
  modport sink (input valid, operation, byte_value, adc_data_in, output ready);
endinterface
`default_nettype wire

@@ design/tdsm_out_if.sv @@
`default_nettype none
interface tdsm_out_if;
  logic       valid;
  logic       ready;
  logic       lcd_clock;
  logic       lcd_data;
  logic       lcd_select_n;
  logic       lcd_is_data;
  logic       activity_led;
  logic       adc_clock;
  logic       adc_select_n;
  logic [7:0] adc_result;
  logic       send_busy;
  logic       read_busy;
  logic       start_rejected;

  modport source (
    output valid, lcd_clock, lcd_data, lcd_select_n, lcd_is_data, activity_led,
           adc_clock, adc_select_n, adc_result, send_busy, read_busy, start_rejected,
    input  ready
  );
  modport sink (
    input  valid, lcd_clock, lcd_data, lcd_select_n, lcd_is_data, activity_led,
           adc_clock, adc_select_n, adc_result, send_busy, read_busy, start_rejected,
    output ready
  );
endinterface
`default_nettype wire

@@ design/tdsm_read_engine.sv @@
`default_nettype none
module tdsm_read_engine
  import tdsm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire read_ctrl_t   ctrl,
  output read_status_t      status
);

  logic [3:0] tick_phase, tick_phase_next;
  logic [3:0] frame_bit, frame_bit_next;
  logic [7:0] sample, sample_next;
  logic       active, active_next;
  logic       adc_clock, adc_clock_next;
  logic       adc_select_n, adc_select_n_next;
  logic [2:0] bit_index;

  assign bit_index = 3'(FRAME_LAST_BIT - frame_bit);

  always_comb begin
    tick_phase_next   = tick_phase;
    frame_bit_next    = frame_bit;
    sample_next       = sample;
    active_next       = active;
    adc_clock_next    = adc_clock;
    adc_select_n_next = adc_select_n;
    if (ctrl.start) begin
      tick_phase_next = '0;
      frame_bit_next  = '0;
      active_next     = 1'b1;
    end else if (ctrl.tick) begin
      if (tick_phase == PHASE_CLK_FALL) begin
        adc_clock_next = 1'b0;
      end else if (tick_phase == PHASE_SAMPLE) begin
        if (frame_bit == FRAME_CLEAR) begin
          sample_next = '0;
        end else if (frame_bit >= FRAME_FIRST_BIT && frame_bit <= FRAME_LAST_BIT) begin
          sample_next[bit_index] = sample[bit_index] | ctrl.din;
        end
      end else if (tick_phase == PHASE_LAST) begin
        adc_clock_next = 1'b1;
        if (frame_bit == FRAME_SELECT) begin
          adc_select_n_next = 1'b0;
        end else if (frame_bit == FRAME_LAST) begin
          adc_select_n_next = 1'b1;
          active_next       = 1'b0;
        end
        frame_bit_next = (frame_bit >= FRAME_LAST) ? '0 : frame_bit + 4'd1;
      end
      tick_phase_next = (tick_phase == PHASE_LAST) ? '0 : tick_phase + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase   <= '0;
      frame_bit    <= '0;
      sample       <= '0;
      active       <= 1'b0;
      adc_clock    <= 1'b1;
      adc_select_n <= 1'b1;
    end else begin
      tick_phase   <= tick_phase_next;
      frame_bit    <= frame_bit_next;
      sample       <= sample_next;
      active       <= active_next;
      adc_clock    <= adc_clock_next;
      adc_select_n <= adc_select_n_next;
    end
  end

  assign status.active       = active;
  assign status.adc_clock    = adc_clock;
  assign status.adc_select_n = adc_select_n;
  assign status.sample       = sample;

endmodule
`default_nettype wire

@@ design/tick_driven_serial_master.sv @@
// A result beat is registered and appears the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless results stall; single result register stage.
// Input ready stays high while the result register is empty or being drained.
// Reset is synchronous: counters and busy flags clear, clocks, data and selects go high,
// and the LED and command/data line go low.
`default_nettype none
module tick_driven_serial_master
  import tdsm_pkg::*;
#(
  parameter int SEND_BITS = SEND_BITS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tdsm_in_if.sink    items,
  tdsm_out_if.source results
);

  localparam int SENT_W = $clog2(SEND_BITS + 1);

  logic              accept;
  op_t               op;
  logic [7:0]        shift_byte, shift_byte_next;
  logic [SENT_W-1:0] sent_bits, sent_bits_next;
  logic              send_active, send_active_next;
  logic              lcd_clock, lcd_clock_next;
  logic              lcd_data, lcd_data_next;
  logic              lcd_select_n, lcd_select_n_next;
  logic              lcd_is_data, lcd_is_data_next;
  logic              activity_led, activity_led_next;
  logic              rejected, rejected_next;
  logic              out_valid;
  read_ctrl_t        read_ctrl;
  read_status_t      read_status;

  assign items.ready = !out_valid || results.ready;
  assign accept      = items.valid && items.ready;
  assign op          = op_t'(items.operation);

  always_comb begin
    shift_byte_next   = shift_byte;
    sent_bits_next    = sent_bits;
    send_active_next  = send_active;
    lcd_clock_next    = lcd_clock;
    lcd_data_next     = lcd_data;
    lcd_select_n_next = lcd_select_n;
    lcd_is_data_next  = lcd_is_data;
    activity_led_next = activity_led;
    rejected_next     = 1'b0;
    read_ctrl.start   = 1'b0;
    read_ctrl.tick    = 1'b0;
    read_ctrl.din     = items.adc_data_in;
    unique case (op)
      OP_CMD, OP_DATA: begin
        if (send_active) begin
          rejected_next = 1'b1;
        end else begin
          lcd_select_n_next = 1'b0;
          lcd_is_data_next  = (op == OP_DATA);
          shift_byte_next   = items.byte_value;
          sent_bits_next    = '0;
          send_active_next  = 1'b1;
        end
      end
      OP_READ: begin
        if (read_status.active) begin
          rejected_next = 1'b1;
        end else begin
          read_ctrl.start = 1'b1;
        end
      end
      OP_TICK: begin
        if (send_active) begin
          if (sent_bits < SENT_W'(SEND_BITS)) begin
            lcd_clock_next    = !lcd_clock;
            activity_led_next = !activity_led;
            if (lcd_clock) begin
              lcd_data_next = shift_byte[7];
            end else begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
              sent_bits_next  = sent_bits + SENT_W'(1);
            end
          end else begin
            sent_bits_next    = '0;
            send_active_next  = 1'b0;
            activity_led_next = 1'b0;
            lcd_select_n_next = 1'b1;
          end
        end else begin
          read_ctrl.tick = read_status.active;
        end
      end
      default: ;
    endcase
    if (!accept) begin
      read_ctrl.start = 1'b0;
      read_ctrl.tick  = 1'b0;
    end
  end

  tdsm_read_engine u_read (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (read_ctrl),
    .status (read_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte   <= '0;
      sent_bits    <= '0;
      send_active  <= 1'b0;
      lcd_clock    <= 1'b1;
      lcd_data     <= 1'b1;
      lcd_select_n <= 1'b1;
      lcd_is_data  <= 1'b0;
      activity_led <= 1'b0;
      rejected     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        shift_byte   <= shift_byte_next;
        sent_bits    <= sent_bits_next;
        send_active  <= send_active_next;
        lcd_clock    <= lcd_clock_next;
        lcd_data     <= lcd_data_next;
        lcd_select_n <= lcd_select_n_next;
        lcd_is_data  <= lcd_is_data_next;
        activity_led <= activity_led_next;
        rejected     <= rejected_next;
        out_valid    <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.lcd_clock      = lcd_clock;
  assign results.lcd_data       = lcd_data;
  assign results.lcd_select_n   = lcd_select_n;
  assign results.lcd_is_data    = lcd_is_data;
  assign results.activity_led   = activity_led;
  assign results.adc_clock      = read_status.adc_clock;
  assign results.adc_select_n   = read_status.adc_select_n;
  assign results.adc_result     = read_status.sample;
  assign results.send_busy      = send_active;
  assign results.read_busy      = read_status.active;
  assign results.start_rejected = rejected;

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import tdsm_pkg::*;

  localparam int SEND_LEN  = SEND_BITS_DEFAULT;
  localparam int FRAME_LEN = 12 * 16;

  typedef struct {
    op_t        op;
    logic [7:0] value;
    logic       din;
  } stim_beat_t;

  typedef struct packed {
    logic       lcd_clock;
    logic       lcd_data;
    logic       lcd_select_n;
    logic       lcd_is_data;
    logic       activity_led;
    logic       adc_clock;
    logic       adc_select_n;
    logic [7:0] adc_result;
    logic       send_busy;
    logic       read_busy;
    logic       start_rejected;
  } pin_levels_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdsm_in_if  in_ch ();
  tdsm_out_if out_ch ();

  tick_driven_serial_master #(.SEND_BITS(SEND_LEN)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stim_beat_t  pending_beats[$];
  pin_levels_t pin_levels_q[$];
  int send_idle_pct = 29;
  int recv_idle_pct = 60;
  int n_accepted = 0;
  int n_errors = 0;
  int n_sends = 0;
  int n_frames = 0;
  int n_rejects = 0;

  // Shadow copy of both engines.
  logic [7:0] tx_shift = 8'h00;
  int         tx_count = 0;
  logic       tx_on = 1'b0;
  logic       rx_on = 1'b0;
  logic [3:0] rx_phase = 4'd0;
  logic [3:0] rx_bit = 4'd0;
  logic [7:0] rx_sample = 8'h00;
  logic       p_lcd_clk = 1'b1;
  logic       p_lcd_dat = 1'b1;
  logic       p_lcd_sel = 1'b1;
  logic       p_lcd_dc = 1'b0;
  logic       p_led = 1'b0;
  logic       p_adc_clk = 1'b1;
  logic       p_adc_sel = 1'b1;

  function automatic pin_levels_t advance_pins(op_t op, logic [7:0] value, logic din);
    pin_levels_t lv;
    logic rejected;
    rejected = 1'b0;
    if (op == OP_CMD || op == OP_DATA) begin
      if (tx_on) begin
        rejected = 1'b1;
      end else begin
        p_lcd_sel = 1'b0;
        p_lcd_dc = (op == OP_DATA);
        tx_shift = value;
        tx_count = 0;
        tx_on = 1'b1;
        n_sends++;
      end
    end else if (op == OP_READ) begin
      if (rx_on) begin
        rejected = 1'b1;
      end else begin
        rx_phase = 4'd0;
        rx_bit = 4'd0;
        rx_on = 1'b1;
      end
    end else if (tx_on) begin
      if (tx_count < SEND_LEN) begin
        p_lcd_clk = !p_lcd_clk;
        p_led = !p_led;
        if (!p_lcd_clk) begin
          p_lcd_dat = tx_shift[7];
        end else begin
          tx_shift = tx_shift << 1;
          tx_count++;
        end
      end else begin
        tx_count = 0;
        tx_on = 1'b0;
        p_led = 1'b0;
        p_lcd_sel = 1'b1;
      end
    end else if (rx_on) begin
      if (rx_phase == PHASE_CLK_FALL) begin
        p_adc_clk = 1'b0;
      end else if (rx_phase == PHASE_SAMPLE) begin
        if (rx_bit == FRAME_CLEAR) begin
          rx_sample = 8'h00;
        end else if (rx_bit >= FRAME_FIRST_BIT && rx_bit <= FRAME_LAST_BIT) begin
          rx_sample[3'(FRAME_LAST_BIT - rx_bit)] = din;
        end
      end else if (rx_phase == PHASE_LAST) begin
        p_adc_clk = 1'b1;
        if (rx_bit == FRAME_SELECT) begin
          p_adc_sel = 1'b0;
        end else if (rx_bit == FRAME_LAST) begin
          p_adc_sel = 1'b1;
          rx_on = 1'b0;
          n_frames++;
        end
        rx_bit = (rx_bit >= FRAME_LAST) ? 4'd0 : rx_bit + 4'd1;
      end
      rx_phase = rx_phase + 4'd1;
    end
    if (rejected) n_rejects++;
    lv.lcd_clock = p_lcd_clk;
    lv.lcd_data = p_lcd_dat;
    lv.lcd_select_n = p_lcd_sel;
    lv.lcd_is_data = p_lcd_dc;
    lv.activity_led = p_led;
    lv.adc_clock = p_adc_clk;
    lv.adc_select_n = p_adc_sel;
    lv.adc_result = rx_sample;
    lv.send_busy = tx_on;
    lv.read_busy = rx_on;
    lv.start_rejected = rejected;
    return lv;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (n_errors < 20) begin
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    n_errors++;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic add_beat(op_t op, logic [7:0] value, logic din);
    stim_beat_t b;
    b.op = op;
    b.value = value;
    b.din = din;
    pending_beats.push_back(b);
  endtask

  task automatic add_ticks(int n);
    for (int i = 0; i < n; i++) begin
      add_beat(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic add_send(op_t op, logic [7:0] value);
    add_beat(op, value, 1'($urandom_range(1)));
    add_ticks(2 * SEND_LEN + 1);
  endtask

  always @(posedge clk) begin : drive_beats
    stim_beat_t b;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = pending_beats.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= b.op;
        in_ch.byte_value <= b.value;
        in_ch.adc_data_in <= b.din;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_beats
    pin_levels_t want;
    if (!rst && in_ch.valid && in_ch.ready) begin
      pin_levels_q.push_back(advance_pins(op_t'(in_ch.operation), in_ch.byte_value,
                                          in_ch.adc_data_in));
      n_accepted++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pin_levels_q.size() == 0) begin
        report_mismatch("unexpected result beat", 8'h00, 8'h00);
      end else begin
        want = pin_levels_q.pop_front();
        check_field("lcd_clock", 8'(out_ch.lcd_clock), 8'(want.lcd_clock));
        check_field("lcd_data", 8'(out_ch.lcd_data), 8'(want.lcd_data));
        check_field("lcd_select_n", 8'(out_ch.lcd_select_n), 8'(want.lcd_select_n));
        check_field("lcd_is_data", 8'(out_ch.lcd_is_data), 8'(want.lcd_is_data));
        check_field("activity_led", 8'(out_ch.activity_led), 8'(want.activity_led));
        check_field("adc_clock", 8'(out_ch.adc_clock), 8'(want.adc_clock));
        check_field("adc_select_n", 8'(out_ch.adc_select_n), 8'(want.adc_select_n));
        check_field("adc_result", out_ch.adc_result, want.adc_result);
        check_field("send_busy", 8'(out_ch.send_busy), 8'(want.send_busy));
        check_field("read_busy", 8'(out_ch.read_busy), 8'(want.read_busy));
        check_field("start_rejected", 8'(out_ch.start_rejected), 8'(want.start_rejected));
      end
    end
  end

  initial begin
    int total;
    int r;
    int n;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_TICK;
    in_ch.byte_value = 8'h00;
    in_ch.adc_data_in = 1'b0;
    out_ch.ready = 1'b0;

    // An idle tick, then a send with a second send and two reads started during it.
    add_beat(OP_TICK, 8'h5A, 1'b1);
    add_beat(OP_CMD, 8'hFF, 1'b0);
    add_beat(OP_DATA, 8'h00, 1'b1);
    add_beat(OP_READ, 8'hFF, 1'b0);
    add_beat(OP_READ, 8'h00, 1'b1);
    add_ticks(2 * SEND_LEN + 1);
    add_send(OP_DATA, 8'h00);

    while (pending_beats.size() < 1050) begin
      r = $urandom_range(99);
      if (r < 45) begin
        add_beat($urandom_range(1) ? OP_DATA : OP_CMD, 8'($urandom_range(255)),
                 1'($urandom_range(1)));
        n = 2 * SEND_LEN + 1;
        if ($urandom_range(7) == 0) begin
          add_ticks($urandom_range(n));
          add_beat(op_t'($urandom_range(3, 1)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
        end
        add_ticks(n);
      end else if (r < 62) begin
        add_beat(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
        for (int i = 0; i < FRAME_LEN; i++) begin
          if ($urandom_range(39) == 0) begin
            add_send($urandom_range(1) ? OP_DATA : OP_CMD, 8'($urandom_range(255)));
          end else if ($urandom_range(59) == 0) begin
            add_beat(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
          end
          add_ticks(1);
        end
      end else if (r < 82) begin
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
          add_beat(op_t'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end else begin
        add_ticks($urandom_range(5, 1));
      end
    end
    total = pending_beats.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < total / 3) @(negedge clk);
    send_idle_pct = 60;
    recv_idle_pct = 29;
    while (n_accepted < 2 * total / 3) @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    while (pending_beats.size() != 0 || in_ch.valid || pin_levels_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
    if (pin_levels_q.size() != 0) report_mismatch("missing result beats", 8'h00, 8'h00);

    $display("covered %0d beats: %0d byte sends, %0d converter frames, %0d rejected starts",
             n_accepted, n_sends, n_frames, n_rejects);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d result beats outstanding", pin_levels_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

@@ tick_driven_serial_master.f @@
design/tdsm_pkg.sv
design/tdsm_in_if.sv
design/tdsm_out_if.sv
design/tdsm_read_engine.sv
design/tick_driven_serial_master.sv
bench/tb.sv
